// File: hw/rtl/rc4_drop_stream_cipher_top_macros.svh
// Assertion macros for the RC4-drop stream cipher.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef RC4_DROP_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_DROP_STREAM_CIPHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define RC4_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rc4 check failed");
// check a property at every edge, reset included
`define RC4_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("rc4 check failed");
`else
`define RC4_ASSERT(label, prop)
`define RC4_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: hw/rtl/rc4_pkg.sv
// Shared types and constants of the RC4-drop stream cipher.
// No dependencies; used by the interfaces and the top level.
package rc4_pkg;

  // key store depth and derived address width
  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);

  // S-box geometry
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = $clog2(SBOX_DEPTH);

  // field widths
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int KEY_LEN_W  = 9;
  localparam int DISC_W     = 26;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 26;

  // configuration reset values
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = KEY_LEN_W'(16);
  localparam logic [DISC_W-1:0]    DISC_RST    = DISC_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_ACCEPTED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH    = 1'd0,
    CFG_DISCARD_COUNT = 1'd1
  } cfg_idx_e;

endpackage

// File: hw/rtl/rc4_if.sv
// Request and result channel interfaces of the RC4-drop stream cipher.
// Depends on rc4_pkg for field widths.
interface rc4_req_if;
  logic                          valid;
  logic                          ready;
  logic [rc4_pkg::OP_W-1:0]      op;
  logic [rc4_pkg::KEY_AW-1:0]    key_index;
  logic [rc4_pkg::BYTE_W-1:0]    value;
  logic                          last;

  modport source (output valid, op, key_index, value, last, input ready);
  modport sink   (input valid, op, key_index, value, last, output ready);
endinterface

interface rc4_res_if;
  logic                          valid;
  logic                          ready;
  logic [rc4_pkg::BYTE_W-1:0]    out_byte;
  logic [rc4_pkg::STATUS_W-1:0]  status;
  logic                          last_res;

  modport source (output valid, out_byte, status, last_res, input ready);
  modport sink   (input valid, out_byte, status, last_res, output ready);
endinterface

// File: hw/rtl/rc4_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; holds the S-box and the key store.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rc4_drop_stream_cipher_top.sv
// RC4-drop stream cipher top level: request sequencer, S-box and key store memories.
// Depends on rc4_pkg, rc4_if, rc4_ram and the assertion macro header.
//
// Requests are key loads, schedule runs and data bytes; each gives exactly one result. A key
// load passes through FINISH to the output register; a data byte passes through PG_RD1,
// PG_RD2, PG_W1, PG_W2 and FINISH; the next request is taken once the sequencer is back in
// IDLE. Every keystream byte makes two dependent reads, one look-up read and two swap writes
// on the S-box memory, which has one write port and one read port. A schedule runs an
// initialisation sweep of the S-box, the states KSA_RD, KSA_J, KSA_W1 and KSA_W2 for each
// key-scheduling swap, the states PG_RD1, PG_RD2, PG_W1 and PG_W2 for each dropped keystream
// byte and FINISH to hand the result over. A new request is taken whenever the sequencer is
// idle, even while the previous result still waits at the output; a result that finds the
// output still occupied holds the sequencer until it is taken.
`include "rc4_drop_stream_cipher_top_macros.svh"

module rc4_drop_stream_cipher_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rc4_req_if.sink                          req_i,
  rc4_res_if.source                        res_o
);

  typedef enum logic [3:0] {
    IDLE,
    INIT,
    KSA_RD,
    KSA_J,
    KSA_W1,
    KSA_W2,
    PG_RD1,
    PG_RD2,
    PG_W1,
    PG_W2,
    FINISH
  } state_e;

  localparam logic [rc4_pkg::SBOX_AW-1:0] SBOX_LAST =
    rc4_pkg::SBOX_AW'(rc4_pkg::SBOX_DEPTH - 1);
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_LEN_MAX =
    rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_DEPTH);

  state_e                            state_q, state_d;
  logic [rc4_pkg::KEY_LEN_W-1:0]     key_length_q, key_length_d;
  logic [rc4_pkg::DISC_W-1:0]        discard_count_q, discard_count_d;
  logic [rc4_pkg::DISC_W-1:0]        disc_cnt_q, disc_cnt_d;
  logic                              disc_mode_q, disc_mode_d;
  logic                              keyed_q, keyed_d;
  logic [rc4_pkg::SBOX_AW-1:0]       n_q, n_d;
  logic [rc4_pkg::KEY_AW-1:0]        k_q, k_d;
  logic [rc4_pkg::SBOX_AW-1:0]       i_q, i_d;
  logic [rc4_pkg::SBOX_AW-1:0]       j_q, j_d;
  logic [rc4_pkg::SBOX_AW-1:0]       t_q, t_d;
  logic [rc4_pkg::BYTE_W-1:0]        si_q, si_d;
  logic [rc4_pkg::BYTE_W-1:0]        sj_q, sj_d;
  logic [rc4_pkg::BYTE_W-1:0]        val_q, val_d;
  logic [rc4_pkg::BYTE_W-1:0]        res_byte_q, res_byte_d;
  logic [rc4_pkg::STATUS_W-1:0]      res_status_q, res_status_d;
  logic                              res_last_q, res_last_d;
  logic                              out_valid_q, out_valid_d;
  logic [rc4_pkg::BYTE_W-1:0]        out_byte_q, out_byte_d;
  logic [rc4_pkg::STATUS_W-1:0]      out_status_q, out_status_d;
  logic                              out_last_q, out_last_d;

  // memory ports
  logic                              s_we;
  logic [rc4_pkg::SBOX_AW-1:0]       s_waddr, s_raddr;
  logic [rc4_pkg::BYTE_W-1:0]        s_wdata, s_rdata;
  logic                              k_we;
  logic [rc4_pkg::KEY_AW-1:0]        k_waddr, k_raddr;
  logic [rc4_pkg::BYTE_W-1:0]        k_wdata, k_rdata;

  logic                              req_acc;
  logic [rc4_pkg::KEY_LEN_W-1:0]     len_eff;
  logic [rc4_pkg::KEY_LEN_W-1:0]     k_plus;
  logic [rc4_pkg::SBOX_AW-1:0]       j_ksa, j_prga, i_next, t_sum;
  logic [rc4_pkg::BYTE_W-1:0]        ks_byte;

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::SBOX_DEPTH)
  ) u_sbox (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::KEY_DEPTH)
  ) u_key (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  assign req_i.ready    = (state_q == IDLE);
  assign req_acc        = req_i.valid && req_i.ready;
  assign res_o.valid    = out_valid_q;
  assign res_o.out_byte = out_byte_q;
  assign res_o.status   = out_status_q;
  assign res_o.last_res = out_last_q;

  // clamp key length to one..depth
  always_comb begin
    if (key_length_q == '0) begin
      len_eff = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length_q > KEY_LEN_MAX) begin
      len_eff = KEY_LEN_MAX;
    end else begin
      len_eff = key_length_q;
    end
  end

  // datapath sums
  assign k_plus = rc4_pkg::KEY_LEN_W'(k_q) + rc4_pkg::KEY_LEN_W'(1);
  assign j_ksa  = rc4_pkg::SBOX_AW'(j_q + s_rdata + k_rdata);
  assign j_prga = rc4_pkg::SBOX_AW'(j_q + s_rdata);
  assign i_next = rc4_pkg::SBOX_AW'(i_q + 1'b1);
  assign t_sum  = rc4_pkg::SBOX_AW'(si_q + s_rdata);

  // forward the swapped entries over the look-up read
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = si_q;
    end else if (t_q == i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = s_rdata;
    end
  end

  // sequencer next state
  always_comb begin
    state_d         = state_q;
    key_length_d    = key_length_q;
    discard_count_d = discard_count_q;
    disc_cnt_d      = disc_cnt_q;
    disc_mode_d     = disc_mode_q;
    keyed_d         = keyed_q;
    n_d             = n_q;
    k_d             = k_q;
    i_d             = i_q;
    j_d             = j_q;
    t_d             = t_q;
    si_d            = si_q;
    sj_d            = sj_q;
    val_d           = val_q;
    res_byte_d      = res_byte_q;
    res_status_d    = res_status_q;
    res_last_d      = res_last_q;
    out_valid_d     = out_valid_q;
    out_byte_d      = out_byte_q;
    out_status_d    = out_status_q;
    out_last_d      = out_last_q;
    s_we            = 1'b0;
    s_waddr         = n_q;
    s_wdata         = n_q;
    s_raddr         = n_q;
    k_we            = 1'b0;
    k_waddr         = req_i.key_index;
    k_wdata         = req_i.value;
    k_raddr         = k_q;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rc4_pkg::CFG_KEY_LENGTH: begin
          key_length_d = cfg_data_i[rc4_pkg::KEY_LEN_W-1:0];
        end
        rc4_pkg::CFG_DISCARD_COUNT: begin
          discard_count_d = cfg_data_i[rc4_pkg::DISC_W-1:0];
        end
        default: begin
        end
      endcase
    end

    // drop the result once taken
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      IDLE: begin
        if (req_acc) begin
          val_d        = req_i.value;
          res_last_d   = req_i.last;
          res_byte_d   = '0;
          res_status_d = rc4_pkg::ST_ACCEPTED;
          case (req_i.op)
            rc4_pkg::OP_LOAD: begin
              k_we    = ({1'b0, req_i.key_index} < KEY_LEN_MAX);
              state_d = FINISH;
            end
            rc4_pkg::OP_SCHED: begin
              n_d     = '0;
              state_d = INIT;
            end
            rc4_pkg::OP_DATA: begin
              if (keyed_q) begin
                disc_mode_d = 1'b0;
                state_d     = PG_RD1;
              end else begin
                res_status_d = rc4_pkg::ST_REFUSED;
                state_d      = FINISH;
              end
            end
            default: begin
              state_d = FINISH;
            end
          endcase
        end
      end
      INIT: begin
        // fill the S-box with the identity
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = n_q;
        n_d     = n_q + 1'b1;
        if (n_q == SBOX_LAST) begin
          k_d     = '0;
          j_d     = '0;
          state_d = KSA_RD;
        end
      end
      KSA_RD: begin
        s_raddr = n_q;
        k_raddr = k_q;
        state_d = KSA_J;
      end
      KSA_J: begin
        j_d     = j_ksa;
        si_d    = s_rdata;
        s_raddr = j_ksa;
        state_d = KSA_W1;
      end
      KSA_W1: begin
        s_we    = 1'b1;
        s_waddr = n_q;
        s_wdata = s_rdata;
        state_d = KSA_W2;
      end
      KSA_W2: begin
        // complete the swap and advance the key position
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        n_d     = n_q + 1'b1;
        k_d     = (k_plus >= len_eff) ? '0 : k_plus[rc4_pkg::KEY_AW-1:0];
        if (n_q == SBOX_LAST) begin
          i_d = '0;
          j_d = '0;
          if (discard_count_q == '0) begin
            keyed_d = 1'b1;
            state_d = FINISH;
          end else begin
            disc_cnt_d  = discard_count_q;
            disc_mode_d = 1'b1;
            state_d     = PG_RD1;
          end
        end else begin
          state_d = KSA_RD;
        end
      end
      PG_RD1: begin
        i_d     = i_next;
        s_raddr = i_next;
        state_d = PG_RD2;
      end
      PG_RD2: begin
        j_d     = j_prga;
        si_d    = s_rdata;
        s_raddr = j_prga;
        state_d = PG_W1;
      end
      PG_W1: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        sj_d    = s_rdata;
        t_d     = t_sum;
        s_raddr = t_sum;
        state_d = PG_W2;
      end
      PG_W2: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        if (disc_mode_q) begin
          disc_cnt_d = disc_cnt_q - 1'b1;
          if (disc_cnt_q == rc4_pkg::DISC_W'(1)) begin
            keyed_d = 1'b1;
            state_d = FINISH;
          end else begin
            state_d = PG_RD1;
          end
        end else begin
          res_byte_d   = val_q ^ ks_byte;
          res_status_d = rc4_pkg::ST_DONE;
          state_d      = FINISH;
        end
      end
      FINISH: begin
        // hand the result over once the output register is free
        if (!out_valid_q || res_o.ready) begin
          out_valid_d  = 1'b1;
          out_byte_d   = res_byte_q;
          out_status_d = res_status_q;
          out_last_d   = res_last_q;
          state_d      = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= IDLE;
      key_length_q    <= rc4_pkg::KEY_LEN_RST;
      discard_count_q <= rc4_pkg::DISC_RST;
      disc_cnt_q      <= '0;
      disc_mode_q     <= 1'b0;
      keyed_q         <= 1'b0;
      n_q             <= '0;
      k_q             <= '0;
      i_q             <= '0;
      j_q             <= '0;
      t_q             <= '0;
      si_q            <= '0;
      sj_q            <= '0;
      val_q           <= '0;
      res_byte_q      <= '0;
      res_status_q    <= '0;
      res_last_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      out_byte_q      <= '0;
      out_status_q    <= '0;
      out_last_q      <= 1'b0;
    end else begin
      state_q         <= state_d;
      key_length_q    <= key_length_d;
      discard_count_q <= discard_count_d;
      disc_cnt_q      <= disc_cnt_d;
      disc_mode_q     <= disc_mode_d;
      keyed_q         <= keyed_d;
      n_q             <= n_d;
      k_q             <= k_d;
      i_q             <= i_d;
      j_q             <= j_d;
      t_q             <= t_d;
      si_q            <= si_d;
      sj_q            <= sj_d;
      val_q           <= val_d;
      res_byte_q      <= res_byte_d;
      res_status_q    <= res_status_d;
      res_last_q      <= res_last_d;
      out_valid_q     <= out_valid_d;
      out_byte_q      <= out_byte_d;
      out_status_q    <= out_status_d;
      out_last_q      <= out_last_d;
    end
  end

  // a processed data byte only ever leaves a keyed block
  `RC4_ASSERT(a_done_needs_key, res_o.valid && res_o.status == rc4_pkg::ST_DONE |-> keyed_q)
  // every result other than processed data carries a zero byte
  `RC4_ASSERT(a_zero_byte, res_o.valid && res_o.status != rc4_pkg::ST_DONE |-> res_o.out_byte == '0)
  // S-box writes only come from the fill, swap and keystream steps
  `RC4_ASSERT(a_sbox_write, s_we |-> state_q == INIT || state_q == KSA_W1 || state_q == KSA_W2 || state_q == PG_W1 || state_q == PG_W2)
  // a drop step never starts with the count exhausted
  `RC4_ASSERT(a_drop_count, state_q == PG_RD1 && disc_mode_q |-> disc_cnt_q != '0)
  // an accepted request always leaves the idle state
  `RC4_ASSERT(a_accept_busy, req_acc |=> state_q != IDLE)
  // no result is shown straight out of reset
  `RC4_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !res_o.valid || $past(rst_ni))

endmodule

// File: test/rc4_cipher_checker.sv
// Checker for the RC4-drop stream cipher: watches the register port and both channels.
// Keeps its own copy of the permutation and key store, and compares each result in order.
// Depends on rc4_pkg and the channel interfaces in rc4_if.
module rc4_cipher_checker
  import rc4_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rc4_req_if                    req_mon,
  rc4_res_if                    res_mon,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_e           status;
    logic              last_res;
  } cipher_res_t;

  // predicted cipher state
  logic [BYTE_W-1:0]    perm [SBOX_DEPTH];
  logic [BYTE_W-1:0]    key_bytes [KEY_DEPTH];
  logic [BYTE_W-1:0]    walk_i;
  logic [BYTE_W-1:0]    walk_j;
  logic                 armed;
  logic [KEY_LEN_W-1:0] key_len_q;
  logic [DISC_W-1:0]    drop_q;
  cipher_res_t          awaited_res [$];

  // advance the generator by one step and return the keystream byte
  function automatic logic [BYTE_W-1:0] keystream_byte();
    logic [BYTE_W-1:0] swap;
    logic [BYTE_W-1:0] pick;
    walk_i = walk_i + 8'd1;
    walk_j = walk_j + perm[walk_i];
    swap = perm[walk_i];
    perm[walk_i] = perm[walk_j];
    perm[walk_j] = swap;
    pick = perm[walk_i] + perm[walk_j];
    return perm[pick];
  endfunction

  // rebuild the permutation from the key store, then throw away the drop count
  function automatic void rekey_and_drop();
    int                span;
    int                k;
    logic [BYTE_W-1:0] mix;
    logic [BYTE_W-1:0] swap;
    span = (key_len_q == 0) ? 1 : ((key_len_q > KEY_DEPTH) ? KEY_DEPTH : int'(key_len_q));
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      perm[n] = n[BYTE_W-1:0];
    end
    mix = '0;
    k = 0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      mix = mix + perm[n] + key_bytes[k];
      swap = perm[n];
      perm[n] = perm[mix];
      perm[mix] = swap;
      k++;
      if (k >= span) begin
        k = 0;
      end
    end
    walk_i = '0;
    walk_j = '0;
    for (int unsigned d = 0; d < drop_q; d++) begin
      void'(keystream_byte());
    end
    armed = 1'b1;
  endfunction

  // work out the result of one request and update the state
  function automatic cipher_res_t cipher_step(logic [OP_W-1:0] op, logic [KEY_AW-1:0] idx,
                                              logic [BYTE_W-1:0] val, logic last);
    cipher_res_t r;
    r.out_byte = '0;
    r.status   = ST_ACCEPTED;
    r.last_res = last;
    case (op)
      OP_LOAD: begin
        key_bytes[idx] = val;
      end
      OP_SCHED: begin
        rekey_and_drop();
      end
      OP_DATA: begin
        if (armed) begin
          r.out_byte = val ^ keystream_byte();
          r.status   = ST_DONE;
        end else begin
          r.status = ST_REFUSED;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // track register writes, check results, then queue the prediction for a new request
  always @(posedge clk_i or negedge rst_ni) begin : watch
    cipher_res_t want;
    if (!rst_ni) begin
      for (int n = 0; n < SBOX_DEPTH; n++) begin
        perm[n]      = '0;
        key_bytes[n] = '0;
      end
      walk_i    = '0;
      walk_j    = '0;
      armed     = 1'b0;
      key_len_q = KEY_LEN_RST;
      drop_q    = DISC_RST;
      awaited_res.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_LENGTH:    key_len_q = cfg_data_i[KEY_LEN_W-1:0];
          CFG_DISCARD_COUNT: drop_q    = cfg_data_i[DISC_W-1:0];
          default: begin
          end
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_res.size() == 0) begin
          $error("result with no request waiting: out_byte %02h status %0d last_res %0b",
                 res_mon.out_byte, res_mon.status, res_mon.last_res);
          fail_count_o++;
        end else begin
          want = awaited_res.pop_front();
          if (res_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, res_mon.out_byte);
            fail_count_o++;
          end
          if (res_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_mon.status);
            fail_count_o++;
          end
          if (res_mon.last_res !== want.last_res) begin
            $error("last_res: expected %0b, got %0b", want.last_res, res_mon.last_res);
            fail_count_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_res.push_back(cipher_step(req_mon.op, req_mon.key_index, req_mon.value,
                                          req_mon.last));
      end
      pending_o = awaited_res.size();
    end
  end

endmodule

// File: test/testbench.sv
// Top of the RC4-drop stream cipher testbench: clock, reset, register writes and requests.
// Drives directed then random key, schedule and data requests with random gaps and stalls.
// Depends on rc4_pkg, rc4_if, the cipher top level and rc4_cipher_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              RAND_ITEMS  = 550;
  localparam int              SETTLE_CYC  = 8;
  localparam int              CYCLE_LIMIT = 3_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;

  // stimulus bookkeeping
  logic [KEY_LEN_W-1:0]  len_set = KEY_LEN_RST;
  logic [KEY_DEPTH-1:0]  key_seen = '0;
  bit                    steady = 1'b0;
  int                    req_count = 0;

  rc4_req_if req_ch ();
  rc4_res_if res_ch ();

  rc4_drop_stream_cipher_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  rc4_cipher_checker cipher_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_mon      (req_ch),
    .res_mon      (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  // effective number of key bytes the schedule reads
  function automatic int key_span();
    return (len_set == 0) ? 1 : ((len_set > KEY_DEPTH) ? KEY_DEPTH : int'(len_set));
  endfunction

  // present one request after a random gap and hold it until the cipher takes it
  task automatic send(logic [OP_W-1:0] op, logic [KEY_AW-1:0] idx, logic [BYTE_W-1:0] val,
                      logic last);
    int gap;
    gap = idle_draw();
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.key_index <= idx;
    req_ch.value     <= val;
    req_ch.last      <= last;
    do @(posedge clk_i); while (!req_ch.ready);
    if (op == OP_LOAD) begin
      key_seen[idx] = 1'b1;
    end
    if (op != OP_UNUSED) begin
      req_count++;
    end
  endtask

  // drop valid and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEY_LENGTH) begin
      len_set = data[KEY_LEN_W-1:0];
    end
  endtask

  // load any key byte the schedule would read unwritten, then run the schedule
  task automatic schedule();
    for (int k = 0; k < key_span(); k++) begin
      if (!key_seen[k]) begin
        send(OP_LOAD, k[KEY_AW-1:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    send(OP_SCHED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_drop();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return 26'($urandom_range(0, 64));
    end else begin
      return 26'($urandom_range(65, 2048));
    end
  endfunction

  // one message: optional reconfiguration, a few key loads, a schedule and data bytes
  task automatic session(int round);
    int                   loads;
    int                   bytes;
    logic [KEY_LEN_W-1:0] len_new;
    steady = ($urandom_range(0, 3) == 0);
    if (round < 4 || $urandom_range(0, 4) == 0) begin
      drain();
      case (round)
        0:       len_new = 9'd256;
        1:       len_new = 9'd0;
        2:       len_new = 9'h1FF;
        3:       len_new = 9'd1;
        default: len_new = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                                       : 9'($urandom_range(1, 32));
      endcase
      write_reg(CFG_KEY_LENGTH, {17'($urandom), len_new});
      if (round < 4 || $urandom_range(0, 1) == 0) begin
        write_reg(CFG_DISCARD_COUNT, (round == 0) ? '0 : pick_drop());
      end
    end
    loads = $urandom_range(0, 4);
    for (int n = 0; n < loads; n++) begin
      send(OP_LOAD,
           ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, key_span() - 1)),
           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    schedule();
    if ($urandom_range(0, 7) == 0) begin
      schedule();
    end
    bytes = $urandom_range(1, 24);
    for (int b = 0; b < bytes; b++) begin
      // scatter stray requests through the message
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
        end else begin
          send(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
        end
      end
      send(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           (b == bytes - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  // accept results after a random stall per result
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int round;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_KEY_LENGTH;
    cfg_data_i       = '0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_LOAD;
    req_ch.key_index = '0;
    req_ch.value     = '0;
    req_ch.last      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // data and a stray opcode before any key exists
    send(OP_DATA, 8'h00, 8'hFF, 1'b1);
    send(OP_DATA, 8'hFF, 8'h00, 1'b0);
    send(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
    // key under the reset configuration, extremes of index and value
    send(OP_LOAD, 8'd0, 8'hFF, 1'b0);
    send(OP_LOAD, 8'd1, 8'h00, 1'b1);
    for (int k = 2; k < 16; k++) begin
      send(OP_LOAD, k[KEY_AW-1:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    send(OP_LOAD, 8'hFF, 8'hFF, 1'b1);
    schedule();
    send(OP_DATA, 8'h00, 8'h00, 1'b0);
    send(OP_DATA, 8'hFF, 8'hFF, 1'b1);
    send(OP_UNUSED, 8'h00, 8'h00, 1'b0);
    schedule();
    send(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);

    // largest drop count: the running keystream must carry on unchanged, key loads too
    drain();
    write_reg(CFG_DISCARD_COUNT, '1);
    send(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    send(OP_LOAD, 8'd3, 8'($urandom_range(0, 255)), 1'b0);
    send(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
    drain();
    write_reg(CFG_DISCARD_COUNT, pick_drop());

    // random messages
    req_count = 0;
    round = 0;
    while (req_count < RAND_ITEMS) begin
      session(round);
      round++;
    end

    drain();
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_if.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_drop_stream_cipher_top.sv
test/rc4_cipher_checker.sv
test/testbench.sv
